// ----- design/sldc_pkg.sv -----
// ----------------------------------------------------------------------------
// sldc_pkg
// Shared types and constants for the scanline lane drift check.
// ----------------------------------------------------------------------------
package sldc_pkg;

   localparam int PIX_W   = 8;
   localparam int COORD_W = 12;
   localparam int GEOM_W  = 13;
   localparam int TOL_W   = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [GEOM_W-1:0] MAX_WIDTH  = 13'd4096;
   localparam logic [GEOM_W-1:0] MAX_HEIGHT = 13'd4096;
   localparam logic [GEOM_W-1:0] MIN_WIDTH  = 13'd2;
   localparam logic [GEOM_W-1:0] MIN_HEIGHT = 13'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd4;

   localparam logic [PIX_W-1:0]  RST_THRESHOLD = 8'd180;
   localparam logic [GEOM_W-1:0] RST_OFFSET    = 13'd20;
   localparam logic [TOL_W-1:0]  RST_TOLERANCE = 12'd15;
   localparam logic [GEOM_W-1:0] RST_WIDTH     = 13'd640;
   localparam logic [GEOM_W-1:0] RST_HEIGHT    = 13'd480;

   localparam logic signed [1:0] VERDICT_CENTER = 2'sb00;
   localparam logic signed [1:0] VERDICT_RIGHT  = 2'sb01;
   localparam logic signed [1:0] VERDICT_LEFT   = 2'sb11;

   typedef struct packed {
      logic [PIX_W-1:0]   threshold;
      logic [TOL_W-1:0]   tolerance;
      logic [GEOM_W-1:0]  width;
      logic [COORD_W-1:0] last_col;
      logic [COORD_W-1:0] center;
      logic [COORD_W-1:0] last_row;
      logic               scan_ok;
      logic [COORD_W-1:0] scan_row;
   } geom_type;

   typedef struct packed {
      logic signed [1:0]  verdict;
      logic               left_found;
      logic               right_found;
      logic [COORD_W-1:0] left_column;
      logic [COORD_W-1:0] right_column;
   } result_type;

endpackage

// ----- design/sldc_csr.sv -----
// ----------------------------------------------------------------------------
// sldc_csr
// Configuration registers and the clamped frame geometry derived from them.
// ----------------------------------------------------------------------------
module sldc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [sldc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sldc_pkg::CSR_DATA_W-1:0] csr_data,
   output sldc_pkg::geom_type             geom
);
   import sldc_pkg::*;

   logic [PIX_W-1:0]  threshold_ff;
   logic [GEOM_W-1:0] offset_ff;
   logic [TOL_W-1:0]  tolerance_ff;
   logic [GEOM_W-1:0] width_ff;
   logic [GEOM_W-1:0] height_ff;

   logic [GEOM_W-1:0] width_eff;
   logic [GEOM_W-1:0] height_eff;
   logic [GEOM_W-1:0] last_col_w;
   logic [GEOM_W-1:0] last_row_w;
   logic [GEOM_W-1:0] scan_row_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RST_THRESHOLD;
         offset_ff    <= RST_OFFSET;
         tolerance_ff <= RST_TOLERANCE;
         width_ff     <= RST_WIDTH;
         height_ff    <= RST_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data[PIX_W-1:0];
            CSR_OFFSET:    offset_ff    <= csr_data;
            CSR_TOLERANCE: tolerance_ff <= csr_data[TOL_W-1:0];
            CSR_WIDTH:     width_ff     <= csr_data;
            CSR_HEIGHT:    height_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < MIN_WIDTH)
         width_eff = MIN_WIDTH;
      else if (width_ff > MAX_WIDTH)
         width_eff = MAX_WIDTH;
      else
         width_eff = width_ff;

      if (height_ff < MIN_HEIGHT)
         height_eff = MIN_HEIGHT;
      else if (height_ff > MAX_HEIGHT)
         height_eff = MAX_HEIGHT;
      else
         height_eff = height_ff;

      last_col_w = width_eff - 13'd1;
      last_row_w = height_eff - 13'd1;
      scan_row_w = height_eff - offset_ff;

      geom.threshold = threshold_ff;
      geom.tolerance = tolerance_ff;
      geom.width     = width_eff;
      geom.last_col  = last_col_w[COORD_W-1:0];
      geom.center    = width_eff[GEOM_W-1:1];
      geom.last_row  = last_row_w[COORD_W-1:0];
      geom.scan_ok   = (offset_ff != '0) && (offset_ff <= height_eff);
      geom.scan_row  = scan_row_w[COORD_W-1:0];
   end

endmodule

// ----- design/sldc_track.sv -----
// ----------------------------------------------------------------------------
// sldc_track
// Column/row counters, marker capture on the scan row and frame verdict.
// ----------------------------------------------------------------------------
module sldc_track (
   input  logic                       clock,
   input  logic                       reset,
   input  sldc_pkg::geom_type         geom,
   input  logic                       step,
   input  logic [sldc_pkg::PIX_W-1:0] pixel_value,
   input  logic                       frame_start,
   output logic                       done,
   output sldc_pkg::result_type       result
);
   import sldc_pkg::*;

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] left_ff, left_in;
   logic [COORD_W-1:0] right_ff, right_in;
   logic               left_valid_ff, left_valid_in;
   logic               right_valid_ff, right_valid_in;

   logic [COORD_W-1:0] col_cur, row_cur, left_cur, right_cur;
   logic               left_valid_cur, right_valid_cur;
   logic               hit;
   logic               row_end;
   logic [COORD_W:0]   pair_sum;
   logic [COORD_W-1:0] mid;
   logic [COORD_W+1:0] upper_bound;
   logic [COORD_W+1:0] lower_sum;

   always_comb begin
      col_cur         = frame_start ? '0 : col_ff;
      row_cur         = frame_start ? '0 : row_ff;
      left_cur        = frame_start ? '0 : left_ff;
      right_cur       = frame_start ? '0 : right_ff;
      left_valid_cur  = frame_start ? 1'b0 : left_valid_ff;
      right_valid_cur = frame_start ? 1'b0 : right_valid_ff;

      hit = geom.scan_ok && (row_cur == geom.scan_row) && (pixel_value >= geom.threshold);

      left_in       = left_cur;
      left_valid_in = left_valid_cur;
      if (hit && (col_cur != '0) && (col_cur <= geom.center)) begin
         left_in       = col_cur;
         left_valid_in = 1'b1;
      end

      right_in       = right_cur;
      right_valid_in = right_valid_cur;
      if (hit && (col_cur >= geom.center) && ({1'b0, col_cur} < geom.width) &&
          !right_valid_cur) begin
         right_in       = col_cur;
         right_valid_in = 1'b1;
      end

      row_end = (col_cur >= geom.last_col);
      done    = row_end && (row_cur >= geom.last_row);

      // drift = mid - center, compared against +/- tolerance without signs
      pair_sum    = {1'b0, left_in} + {1'b0, right_in};
      mid         = pair_sum[COORD_W:1];
      upper_bound = {2'b00, geom.center} + {2'b00, geom.tolerance};
      lower_sum   = {2'b00, mid} + {2'b00, geom.tolerance};

      result.verdict = VERDICT_CENTER;
      if (left_valid_in && right_valid_in) begin
         if ({2'b00, mid} > upper_bound)
            result.verdict = VERDICT_RIGHT;
         else if (lower_sum < {2'b00, geom.center})
            result.verdict = VERDICT_LEFT;
      end
      result.left_found   = left_valid_in;
      result.right_found  = right_valid_in;
      result.left_column  = left_valid_in ? left_in : '0;
      result.right_column = right_valid_in ? right_in : '0;

      if (done) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_cur + 12'd1;
      end else begin
         col_in = col_cur + 12'd1;
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         left_ff        <= '0;
         right_ff       <= '0;
         left_valid_ff  <= 1'b0;
         right_valid_ff <= 1'b0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (done) begin
            left_ff        <= '0;
            right_ff       <= '0;
            left_valid_ff  <= 1'b0;
            right_valid_ff <= 1'b0;
         end else begin
            left_ff        <= left_in;
            right_ff       <= right_in;
            left_valid_ff  <= left_valid_in;
            right_valid_ff <= right_valid_in;
         end
      end
   end

endmodule

// ----- design/scanline_lane_drift_check.sv -----
// ----------------------------------------------------------------------------
// scanline_lane_drift_check
// Raster pixel stream in, one lane drift verdict out per frame.
// ----------------------------------------------------------------------------
//  port group | direction | transfer when          | contents
//  req_       | in        | req_valid & !req_stall | one pixel, frame start flag
//  rsp_       | out       | rsp_valid & !rsp_stall | verdict and marker columns
//  csr_       | in        | csr_write              | register index and data
//
//  One pixel per cycle unless stalled; input register, then result register.
//  A verdict leaves on the last pixel of each frame; other pixels give nothing.
//  A held verdict stalls the input register only when it also holds a pixel.
//  Synchronous reset restores the register defaults and clears the frame.
// ----------------------------------------------------------------------------
module scanline_lane_drift_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sldc_pkg::PIX_W-1:0]      req_pixel_value,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [1:0]               rsp_verdict,
   output logic                            rsp_left_found,
   output logic                            rsp_right_found,
   output logic [sldc_pkg::COORD_W-1:0]    rsp_left_column,
   output logic [sldc_pkg::COORD_W-1:0]    rsp_right_column,
   input  logic                            csr_write,
   input  logic [sldc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sldc_pkg::CSR_DATA_W-1:0] csr_data
);
   import sldc_pkg::*;

   geom_type   geom;
   result_type result;
   logic       done;
   logic       advance;
   logic       step;

   logic             stage_valid_ff, stage_valid_in;
   logic [PIX_W-1:0] stage_pixel_ff;
   logic             stage_start_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;

   sldc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   sldc_track u_track (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .step        (step),
      .pixel_value (stage_pixel_ff),
      .frame_start (stage_start_ff),
      .done        (done),
      .result      (result)
   );

   always_comb begin
      advance        = !rsp_valid_ff || !rsp_stall;
      step           = stage_valid_ff && advance;
      req_stall      = stage_valid_ff && !advance;
      stage_valid_in = req_stall ? stage_valid_ff : req_valid;
      rsp_valid_in   = advance ? (step && done) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_pixel_ff <= req_pixel_value;
         stage_start_ff <= req_frame_start;
      end
      if (step && done)
         rsp_data_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_data_ff.verdict;
   assign rsp_left_found   = rsp_data_ff.left_found;
   assign rsp_right_found  = rsp_data_ff.right_found;
   assign rsp_left_column  = rsp_data_ff.left_column;
   assign rsp_right_column = rsp_data_ff.right_column;

`ifndef SYNTHESIS
   a_verdict_needs_markers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_left_found && rsp_right_found) |-> rsp_verdict == VERDICT_CENTER)
      else $error("drift verdict without both markers");

   a_left_column_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_left_found |-> rsp_left_column == '0)
      else $error("left column set without left marker");

   a_left_not_col0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_left_found |-> rsp_left_column != '0)
      else $error("left marker at column 0");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- sim/drift_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drift_checker
// Watches the pixel, verdict and register ports of the lane drift block.
// It keeps its own copy of the registers and frame state, works out the
// verdict of every completed frame and compares each verdict transfer, field
// by field, with the oldest verdict still owed.
// ----------------------------------------------------------------------------
module drift_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sldc_pkg::PIX_W-1:0]      req_pixel_value,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [1:0]               rsp_verdict,
   input  logic                            rsp_left_found,
   input  logic                            rsp_right_found,
   input  logic [sldc_pkg::COORD_W-1:0]    rsp_left_column,
   input  logic [sldc_pkg::COORD_W-1:0]    rsp_right_column,
   input  logic                            csr_write,
   input  logic [sldc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sldc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              mismatches,
   output int                              outstanding
);

   import sldc_pkg::*;

   logic [PIX_W-1:0]  threshold;
   logic [GEOM_W-1:0] offset;
   logic [TOL_W-1:0]  tolerance;
   logic [GEOM_W-1:0] width_reg;
   logic [GEOM_W-1:0] height_reg;

   int col_count;
   int row_count;
   int left_col;
   int right_col;
   bit left_seen;
   bit right_seen;

   result_type owed_verdicts[$];

   task automatic clear_frame();
      col_count  = 0;
      row_count  = 0;
      left_col   = 0;
      right_col  = 0;
      left_seen  = 1'b0;
      right_seen = 1'b0;
   endtask

   task automatic scan_pixel(input logic [PIX_W-1:0] pix, input logic start);
      int w;
      int h;
      int center;
      int scan_row;
      int mid;
      int drift;
      bit scan_ok;
      result_type res;
      w = width_reg;
      h = height_reg;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < MIN_HEIGHT) h = MIN_HEIGHT;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      center   = w / 2;
      scan_ok  = (offset >= 1) && (offset <= h);
      scan_row = scan_ok ? h - offset : 0;
      if (start) clear_frame();
      if (scan_ok && row_count == scan_row && pix >= threshold) begin
         if (col_count >= 1 && col_count <= center) begin
            left_col  = col_count;
            left_seen = 1'b1;
         end
         if (col_count >= center && col_count < w && !right_seen) begin
            right_col  = col_count;
            right_seen = 1'b1;
         end
      end
      if (col_count >= w - 1) begin
         if (row_count >= h - 1) begin
            res.verdict = VERDICT_CENTER;
            if (left_seen && right_seen) begin
               mid   = (left_col + right_col) / 2;
               drift = mid - center;
               if (drift > int'(tolerance)) res.verdict = VERDICT_RIGHT;
               else if (drift < -int'(tolerance)) res.verdict = VERDICT_LEFT;
            end
            res.left_found   = left_seen;
            res.right_found  = right_seen;
            res.left_column  = left_seen ? left_col[COORD_W-1:0] : '0;
            res.right_column = right_seen ? right_col[COORD_W-1:0] : '0;
            owed_verdicts.push_back(res);
            clear_frame();
         end else begin
            col_count = 0;
            row_count++;
         end
      end else begin
         col_count++;
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         threshold  = RST_THRESHOLD;
         offset     = RST_OFFSET;
         tolerance  = RST_TOLERANCE;
         width_reg  = RST_WIDTH;
         height_reg = RST_HEIGHT;
         clear_frame();
         owed_verdicts.delete();
         mismatches = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_THRESHOLD: threshold  = csr_data[PIX_W-1:0];
               CSR_OFFSET:    offset     = csr_data;
               CSR_TOLERANCE: tolerance  = csr_data[TOL_W-1:0];
               CSR_WIDTH:     width_reg  = csr_data;
               CSR_HEIGHT:    height_reg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_verdicts.size() == 0) begin
               $display("%0t: verdict transfer expected none actual %0d %0b %0b %0d %0d",
                        $time, rsp_verdict, rsp_left_found, rsp_right_found,
                        rsp_left_column, rsp_right_column);
               mismatches++;
            end else begin
               want = owed_verdicts.pop_front();
               check_field("verdict", $signed(want.verdict), rsp_verdict);
               check_field("left_found", want.left_found, rsp_left_found);
               check_field("right_found", want.right_found, rsp_right_found);
               check_field("left_column", want.left_column, rsp_left_column);
               check_field("right_column", want.right_column, rsp_right_column);
            end
         end
         if (req_valid && !req_stall) scan_pixel(req_pixel_value, req_frame_start);
      end
      outstanding = owed_verdicts.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel frames and register settings into the lane drift block: a
// directed set of frames for each marker and geometry corner, rows and frames
// begun at the largest width and height, then random small frames under
// random settings and idle patterns. A side checker scores every verdict.
// ----------------------------------------------------------------------------
module testbench;

   import sldc_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_LIMIT  = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [1:0]     rsp_verdict;
   logic                  rsp_left_found;
   logic                  rsp_right_found;
   logic [COORD_W-1:0]    rsp_left_column;
   logic [COORD_W-1:0]    rsp_right_column;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatches;
   int outstanding;
   int send_idle = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int pixels_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   scanline_lane_drift_check dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_left_found   (rsp_left_found),
      .rsp_right_found  (rsp_right_found),
      .rsp_left_column  (rsp_left_column),
      .rsp_right_column (rsp_right_column),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   drift_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_left_found   (rsp_left_found),
      .rsp_right_found  (rsp_right_found),
      .rsp_left_column  (rsp_left_column),
      .rsp_right_column (rsp_right_column),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_frame_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // drop valid, let owed verdicts drain, then let the pipeline empty
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(input int thr, input int off, input int tol,
                            input int w, input int h);
      logic [CSR_IDX_W-1:0] idx [5];
      int val [5];
      idx = '{CSR_THRESHOLD, CSR_OFFSET, CSR_TOLERANCE, CSR_WIDTH, CSR_HEIGHT};
      val = '{thr, off, tol, w, h};
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i][CSR_DATA_W-1:0];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   initial begin : stimulus
      int thr;
      int off;
      int tol;
      int w;
      int h;
      int full;
      int n;
      int r;
      int phase;
      int base;
      bit start;
      bit restart_due;
      logic [PIX_W-1:0] pix;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle = 15;
      stall_pct = 15;

      // column 0 never counts; a value one below the threshold is dark
      load_regs(255, 1, 0, 4, 1);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd254, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      quiesce();

      // left drift, then a partial frame without a start, then right drift
      load_regs(200, 1, 0, 8, 1);
      for (int c = 0; c < 8; c++) send_pixel((c == 1 || c == 5) ? 8'd255 : 8'd0, c == 0);
      for (int c = 0; c < 3; c++) send_pixel(8'd255, 1'b0);
      for (int c = 0; c < 8; c++) send_pixel((c == 3 || c == 7) ? 8'd255 : 8'd0, c == 0);
      quiesce();

      // zero offset, width below minimum, zero height
      load_regs(0, 0, 4095, 1, 0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      quiesce();

      // offset past the height
      load_regs(0, 3, 0, 0, 2);
      for (int c = 0; c < 4; c++) send_pixel(8'd255, c == 0);
      quiesce();

      send_idle = 0;
      stall_pct = 0;

      // width register above the maximum: a row begun at full width, then
      // closed by shrinking the width
      load_regs(128, 1, 0, 4097, 1);
      send_pixel(8'd127, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd127, 1'b0);
      quiesce();
      load_regs(128, 1, 0, 4, 1);
      send_pixel(8'd255, 1'b0);
      quiesce();

      // tallest frame: scan row 0, then cut short by shrinking the height
      load_regs(255, 4096, 0, 2, 8191);
      for (int c = 0; c < 6; c++) send_pixel(8'd255, c == 0);
      quiesce();
      load_regs(255, 4096, 0, 2, 1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      quiesce();

      base = pixels_sent;
      phase = 0;
      restart_due = 1'b1;
      while (pixels_sent - base < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin send_idle = 0;  stall_pct = 0;  end
            1: begin send_idle = 82; stall_pct = 0;  end
            2: begin send_idle = 0;  stall_pct = 82; end
            default: begin send_idle = 15; stall_pct = 15; end
         endcase
         r   = $urandom_range(0, 9);
         thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 254);
         w   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
         h   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
         full = ((w < 2) ? 2 : w) * ((h < 1) ? 1 : h);
         r   = $urandom_range(0, 9);
         if (r == 0) off = 0;
         else if (r == 1) off = ((h < 1) ? 1 : h) + $urandom_range(1, 4000);
         else off = $urandom_range(1, (h < 1) ? 1 : h);
         r   = $urandom_range(0, 9);
         tol = (r < 6) ? $urandom_range(0, 3) : (r < 8) ? 4095 : $urandom_range(0, 4095);
         quiesce();
         load_regs(thr, off, tol, w, h);
         repeat ($urandom_range(3, 8)) begin
            n = full;
            if ($urandom_range(0, 19) == 0) n = $urandom_range(1, full - 1);
            start = restart_due || ($urandom_range(0, 99) < 85);
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(0, 99);
               if (r < 20) pix = $urandom_range(0, 255);
               else if (r < 50 || thr == 0) pix = $urandom_range(thr, 255);
               else pix = $urandom_range(0, thr - 1);
               send_pixel(pix, start && (i == 0));
            end
            restart_due = (n < full);
         end
         phase++;
      end

      quiesce();
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
